// ===== hdl/bilinear_rgba_resampler_assert.svh =====
// Assertion macros for the bilinear RGBA resampler.
// Needs a clock, and for BRR_ASSERT a reset, named at each use; no other dependencies.
`ifndef BILINEAR_RGBA_RESAMPLER_ASSERT_SVH
`define BILINEAR_RGBA_RESAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define BRR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BRR_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BRR_ASSERT(label, clk, rst, prop, msg)
`define BRR_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hdl/brr_pkg.sv =====
// Shared types and constants of the bilinear RGBA resampler.
// No dependencies.
`default_nettype none
package brr_pkg;
   localparam int SrcPixelsDefault = 65536;
   localparam int FracBitsDefault  = 16;
   localparam int CsrDataWidth     = 27;
   localparam int CsrIndexWidth    = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_STEP_X     = 3'd2,
      CSR_STEP_Y     = 3'd3,
      CSR_ALPHA_EN   = 3'd4
   } csr_index_type;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] pixel_index;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [7:0]  alpha_in;
      logic [11:0] out_x;
      logic [11:0] out_y;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } rsp_word_type;

   typedef struct packed {
      logic [10:0] src_width;
      logic [10:0] src_height;
      logic [26:0] step_x;
      logic [26:0] step_y;
      logic        alpha_enabled;
   } cfg_type;
endpackage
`default_nettype wire

// ===== hdl/brr_stream_if.sv =====
// Valid/ready stream interface carrying one payload word.
// Payload type given as a type parameter.
`default_nettype none
interface brr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/bilinear_rgba_resampler.sv =====
// Top level of the bilinear RGBA resampler: source memory, read sequencer, output skid.
// Depends on brr_pkg, brr_stream_if, brr_addr_gen, brr_blend and the assert header.
//
//   channel  dir  word            accepted when
//   req      in   req_word_type   req.valid && req.ready
//   rsp      out  rsp_word_type   rsp.valid && rsp.ready
//   csr      in   index + data    csr_write_enable
//
// A write word stores its pixel at once.
// A sample word passes the two register stages of the address front end, loads the
// sequencer, makes four reads of the single memory port, then goes through the blend
// into the result buffer, from which its result is offered.
// Reset is synchronous; the memory is not cleared, unwritten entries read anything.
// Hold the input while a sample is in flight or the result buffer is full.
`default_nettype none
`include "bilinear_rgba_resampler_assert.svh"
module bilinear_rgba_resampler #(
   parameter int SRC_PIXELS = brr_pkg::SrcPixelsDefault,
   parameter int FRAC_BITS  = brr_pkg::FracBitsDefault
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   brr_stream_if.sink                                req,
   brr_stream_if.source                              rsp,
   input  wire logic                                 csr_write_enable,
   input  wire logic [brr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [brr_pkg::CsrDataWidth-1:0]     csr_write_data
);
   import brr_pkg::*;
   localparam int AW = $clog2(SRC_PIXELS);

   cfg_type cfg_ff;
   req_word_type rq;
   logic [31:0] mem [SRC_PIXELS];
   logic [31:0] rd_ff;

   // sequencer: counts 4 neighbour reads per sample
   logic        busy_ff, busy_in;
   logic [1:0]  k_ff, k_in;
   logic        rdv_ff;
   logic [1:0]  rdk_ff;
   logic        gen_v, hold;
   logic [3:0][AW-1:0] addr;
   logic [FRAC_BITS:0] t, fy, t_ff, fy_ff;
   logic        done;
   rsp_word_type sum;

   // two-entry output buffer covers in-flight samples
   rsp_word_type q_ff [2];
   logic [1:0]  cnt_ff;
   logic        wp_ff, rp_ff;
   logic        inflight_ff;
   logic        take_req, pop;

   assign rq = req.payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{11'd256, 11'd256, 27'd65536, 27'd65536, 1'b0};
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  cfg_ff.src_width     <= csr_write_data[10:0];
            CSR_SRC_HEIGHT: cfg_ff.src_height    <= csr_write_data[10:0];
            CSR_STEP_X:     cfg_ff.step_x        <= csr_write_data;
            CSR_STEP_Y:     cfg_ff.step_y        <= csr_write_data;
            CSR_ALPHA_EN:   cfg_ff.alpha_enabled <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // accept only when no sample is in flight and buffer has room
   assign hold = 1'b0;
   assign req.ready = !inflight_ff && (cnt_ff != 2'd2);
   assign take_req  = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;

   brr_addr_gen #(.SRC_PIXELS(SRC_PIXELS), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_gen (
      .clock(clock), .reset(reset),
      .start_i(take_req && rq.operation == OP_SAMPLE), .hold_i(hold),
      .out_x_i(rq.out_x), .out_y_i(rq.out_y), .cfg_i(cfg_ff),
      .valid_o(gen_v), .addr_o(addr), .t_o(t), .fy_o(fy));

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (gen_v) begin
         busy_in = 1'b1;
         k_in    = 2'd0;
      end else if (busy_ff) begin
         k_in = k_ff + 2'd1;
         if (k_ff == 2'd3) busy_in = 1'b0;
      end
   end

   logic [3:0][AW-1:0] addr_ff;
   always_ff @(posedge clock) begin
      if (gen_v) begin
         addr_ff <= addr;
         t_ff    <= t;
         fy_ff   <= fy;
      end
      if (take_req && rq.operation == OP_WRITE && ({16'd0, rq.pixel_index} < 32'(SRC_PIXELS)))
         mem[AW'(rq.pixel_index)] <= {rq.alpha_in, rq.blue_in, rq.green_in, rq.red_in};
      else if (busy_ff)
         rd_ff <= mem[addr_ff[k_ff]];
      rdk_ff <= k_ff;
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= 2'd0;
         rdv_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
         rdv_ff  <= busy_ff;
      end
   end

   brr_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock(clock), .reset(reset), .px_valid_i(rdv_ff), .px_k_i(rdk_ff),
      .px_i(rd_ff), .t_i(t_ff), .fy_i(fy_ff), .done_o(done), .sum_o(sum));

   // sum_o packs channels red at top of the struct order
   rsp_word_type res;
   always_comb begin
      res.red_out   = sum.red_out;
      res.green_out = sum.green_out;
      res.blue_out  = sum.blue_out;
      res.alpha_out = cfg_ff.alpha_enabled ? sum.alpha_out : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (done) q_ff[wp_ff] <= res;
      if (reset) begin
         cnt_ff      <= 2'd0;
         wp_ff       <= 1'b0;
         rp_ff       <= 1'b0;
         inflight_ff <= 1'b0;
      end else begin
         if (done) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, done} - {1'b0, pop};
         if (take_req && rq.operation == OP_SAMPLE) inflight_ff <= 1'b1;
         else if (done) inflight_ff <= 1'b0;
      end
   end

   assign rsp.valid   = (cnt_ff != 2'd0);
   assign rsp.payload = q_ff[rp_ff];

   `BRR_ASSERT(a_no_overflow, clock, reset, !(done && cnt_ff == 2'd2), "result buffer overflow")
   `BRR_ASSERT(a_done_inflight, clock, reset, done |-> inflight_ff, "result without sample")
   `BRR_ASSERT(a_busy_one, clock, reset, gen_v |-> !busy_ff, "sample overlap in sequencer")
endmodule
`default_nettype wire

// ===== hdl/brr_addr_gen.sv =====
// Sample address front end: position, clamp, neighbours, weights.
// Depends on brr_pkg. Two register stages; stalls with hold_i.
`default_nettype none
module brr_addr_gen #(
   parameter int SRC_PIXELS = brr_pkg::SrcPixelsDefault,
   parameter int FRAC_BITS  = brr_pkg::FracBitsDefault,
   parameter int AW         = $clog2(SRC_PIXELS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start_i,
   input  wire logic             hold_i,
   input  wire logic [11:0]      out_x_i,
   input  wire logic [11:0]      out_y_i,
   input  wire brr_pkg::cfg_type cfg_i,
   output logic                  valid_o,
   output logic [3:0][AW-1:0]    addr_o,
   output logic [FRAC_BITS:0]    t_o,
   output logic [FRAC_BITS:0]    fy_o
);
   import brr_pkg::*;
   localparam int PW = 39;
   localparam int IW = PW - FRAC_BITS;

   logic          s1_ff, s1_in, s2_ff, s2_in;
   logic [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic [10:0]   w, h;
   logic [PW-1:0] limx, limy, cx, cy;
   logic [IW-1:0] x0, x1, y0, y1;
   logic [3:0][AW-1:0] addr_ff, addr_in;
   logic [FRAC_BITS:0] t_ff, t_in, fy_ff, fy_in;
   logic [21:0]   r0, r1;

   assign w = (cfg_i.src_width  == 11'd0) ? 11'd1 : cfg_i.src_width;
   assign h = (cfg_i.src_height == 11'd0) ? 11'd1 : cfg_i.src_height;

   always_comb begin
      px_in = hold_i ? px_ff : PW'({27'd0, out_x_i} * {12'd0, cfg_i.step_x});
      py_in = hold_i ? py_ff : PW'({27'd0, out_y_i} * {12'd0, cfg_i.step_y});
      s1_in = hold_i ? s1_ff : start_i;
      s2_in = hold_i ? s2_ff : s1_ff;
      limx = (PW'(w) << FRAC_BITS) - (PW'(1) << (FRAC_BITS - 1));
      limy = (PW'(h) << FRAC_BITS) - (PW'(1) << (FRAC_BITS - 1));
      cx = (px_ff >= limx) ? limx : px_ff;
      cy = (py_ff >= limy) ? limy : py_ff;
      x0 = cx[PW-1:FRAC_BITS];
      y0 = cy[PW-1:FRAC_BITS];
      x1 = ((x0 + IW'(1)) >= IW'(w)) ? '0 : x0 + IW'(1);
      y1 = ((y0 + IW'(1)) >= IW'(h)) ? IW'(h) - IW'(1) : y0 + IW'(1);
      // clamped rows and columns stay below 2048, so 11 bits carry them
      r0 = 22'(y0[10:0]) * 22'(w);
      r1 = 22'(y1[10:0]) * 22'(w);
      addr_in[0] = AW'(r0 + 22'(x0[10:0]));
      addr_in[1] = AW'(r0 + 22'(x1[10:0]));
      addr_in[2] = AW'(r1 + 22'(x0[10:0]));
      addr_in[3] = AW'(r1 + 22'(x1[10:0]));
      t_in  = {1'b0, cx[FRAC_BITS-1:0]};
      fy_in = {1'b0, cy[FRAC_BITS-1:0]};
      if (hold_i) begin
         addr_in = addr_ff;
         t_in    = t_ff;
         fy_in   = fy_ff;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      addr_ff <= addr_in;
      t_ff    <= t_in;
      fy_ff   <= fy_in;
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign valid_o = s2_ff;
   assign addr_o  = addr_ff;
   assign t_o     = t_ff;
   assign fy_o    = fy_ff;
endmodule
`default_nettype wire

// ===== hdl/brr_blend.sv =====
// Weight and accumulate unit: one neighbour pixel per call, four calls per sample.
// Depends on brr_pkg.
`default_nettype none
module brr_blend #(
   parameter int FRAC_BITS = brr_pkg::FracBitsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               px_valid_i,
   input  wire logic [1:0]         px_k_i,
   input  wire logic [31:0]        px_i,
   input  wire logic [FRAC_BITS:0] t_i,
   input  wire logic [FRAC_BITS:0] fy_i,
   output logic                    done_o,
   output brr_pkg::rsp_word_type   sum_o
);
   import brr_pkg::*;
   localparam int WW = 2 * FRAC_BITS + 1;

   logic [FRAC_BITS:0] a, b, one;
   logic [WW-1:0]      wt_ff, wt_in;
   logic               v_ff, last_ff, first_ff;
   logic [31:0]        p_ff;
   logic [3:0][7:0]    acc_ff, acc_in;
   logic [WW+7:0]      prod;
   logic               done_ff;

   assign one = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   always_comb begin
      a = px_k_i[0] ? t_i : one - t_i;
      b = px_k_i[1] ? fy_i : one - fy_i;
      wt_in = WW'(a) * WW'(b);
      for (int c = 0; c < 4; c++) begin
         prod = (WW+8)'(wt_ff) * (WW+8)'(p_ff[8*c +: 8]);
         acc_in[c] = (first_ff ? 8'd0 : acc_ff[c]) + prod[2*FRAC_BITS +: 8];
      end
   end

   always_ff @(posedge clock) begin
      wt_ff    <= wt_in;
      p_ff     <= px_i;
      first_ff <= (px_k_i == 2'd0);
      last_ff  <= (px_k_i == 2'd3);
      if (v_ff) acc_ff <= acc_in;
      if (reset) begin
         v_ff    <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v_ff    <= px_valid_i;
         done_ff <= v_ff && last_ff;
      end
   end

   assign done_o = done_ff;
   assign sum_o  = {acc_ff[0], acc_ff[1], acc_ff[2], acc_ff[3]};
endmodule
`default_nettype wire
